@@ rtl/core/tss_pkg.sv @@
// Package for the tone song sequencer: commands, descriptor type, field widths, defaults.
`default_nettype none

package tss_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NOTE_DEPTH  = 256;
    localparam int DEF_NUM_SONGS   = 8;
    localparam int DEF_PERIOD_BITS = 16;

    // Fixed field widths
    localparam int CMD_W    = 3;
    localparam int SID_W    = 3;
    localparam int NADDR_W  = 8;
    localparam int NPER_W   = 16;
    localparam int START_W  = 8;
    localparam int LEN_W    = 9;
    localparam int TICKS_W  = 8;
    localparam int CMP_W    = 15;

    // Stream payload widths; the data widths are rounded up to whole bytes
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_NOTE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_SONG = 3'd4;

    // Song descriptor as kept in the song table
    typedef struct packed {
        logic               rest;
        logic [TICKS_W-1:0] ticks;
        logic [LEN_W-1:0]   length;
        logic [START_W-1:0] start;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

endpackage

`default_nettype wire

@@ rtl/core/tone_song_sequencer_unit.sv @@
// Top level of the tone song sequencer: note store, song table and tick sequencer.
//
//  Channel   Direction  Transfer when               Payload (low bit first)
//  s_axis    in         s_axis_tvalid & tready      tuser: command; tdata: song_id,
//                                                   note_addr, note_period, song_start,
//                                                   song_length, song_ticks, song_rest
//  m_axis    out        m_axis_tvalid & tready      tdata: tone_period, tone_compare,
//                                                   playing, status_notify
//
//  One transfer in, one transfer out. Note store and song table are read at the input
//  transfer edge; stage 1 then applies the item and registers the result once the
//  result register is free or being emptied, and the result transfers from there.
//  Sustained rate is one item per cycle while the output side keeps taking results.
//  Reset (synchronous, active low) clears the sequencer state; memories are not
//  cleared and need no clearing pass, so the block takes items right after reset.
//  A stalled output holds the result register; the input stage then stalls once
//  its own stage register is occupied.
`default_nettype none

module tone_song_sequencer_unit #(
    parameter int NOTE_DEPTH  = tss_pkg::DEF_NOTE_DEPTH,   // power of two
    parameter int NUM_SONGS   = tss_pkg::DEF_NUM_SONGS,
    parameter int PERIOD_BITS = tss_pkg::DEF_PERIOD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] song_id, [10:3] note_addr, [26:11] note_period, [34:27] song_start,
    // [43:35] song_length, [51:44] song_ticks, [52] song_rest, [55:53] zero
    input  wire logic [tss_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [2:0] command
    input  wire logic [tss_pkg::S_USER_W-1:0]  s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [15:0] tone_period, [30:16] tone_compare, [31] playing, [32] status_notify,
    // [39:33] zero
    output logic      [tss_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    import tss_pkg::*;

    // Derived sizes
    localparam int AW    = $clog2(NOTE_DEPTH);
    localparam int SB    = $clog2(NUM_SONGS);
    localparam int SW    = (PERIOD_BITS < NPER_W) ? PERIOD_BITS : NPER_W;
    localparam int SUMW  = (AW > 10) ? AW : 10;
    localparam int NAW   = (AW > NADDR_W) ? AW : NADDR_W;
    localparam int SIDW  = (SB > SID_W) ? SB : SID_W;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]   in_cmd;
    logic [SID_W-1:0]   in_sid;
    logic [NADDR_W-1:0] in_naddr;
    logic [NPER_W-1:0]  in_nper;
    t_desc              in_desc;

    assign in_cmd       = s_axis_tuser[2:0];
    assign in_sid       = s_axis_tdata[2:0];
    assign in_naddr     = s_axis_tdata[10:3];
    assign in_nper      = s_axis_tdata[26:11];
    assign in_desc.start  = s_axis_tdata[34:27];
    assign in_desc.length = s_axis_tdata[43:35];
    assign in_desc.ticks  = s_axis_tdata[51:44];
    assign in_desc.rest   = s_axis_tdata[52];

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic               r_v1;        // stage 1 holds an item
    logic [CMD_W-1:0]   r_cmd1;
    logic [SID_W-1:0]   r_sid1;
    t_desc              r_pay1;      // descriptor payload carried for a song load
    logic               r_ov;        // result register full
    logic               s1_go;
    logic               in_xfer;

    assign s1_go         = r_v1 && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_v1 || s1_go;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [SB-1:0]      r_cur,     n_cur;
    logic               r_active,  n_active;
    logic               r_stop,    n_stop;
    logic [LEN_W-1:0]   r_pos,     n_pos;
    logic [TICKS_W-1:0] r_tc,      n_tc;
    logic [NPER_W-1:0]  r_period,  n_period;
    logic               r_playing, n_playing;
    logic               n_notify;
    t_desc              r_desc,    n_desc;   // copy of the current song's table entry

    // ------------------------------------------------------------------
    // Memories: written at input transfer, read at input transfer
    // ------------------------------------------------------------------
    logic [NAW-1:0]   naddr_ext;
    logic [AW-1:0]    note_waddr;
    logic [SUMW-1:0]  note_sum;
    logic [AW-1:0]    note_raddr;
    logic [SW-1:0]    note_rdata;
    logic             note_we;

    logic [SIDW-1:0]  sid_ext;
    logic [SB-1:0]    sid_idx;
    logic             sid_in_range;
    logic             song_we;
    logic [DESC_W-1:0] song_rdata;

    assign naddr_ext    = NAW'(in_naddr);
    assign note_waddr   = naddr_ext[AW-1:0];
    assign note_we      = in_xfer && (in_cmd == CMD_LOAD_NOTE);

    // Read the note at start plus position as left by the item ahead
    assign note_sum     = SUMW'(n_desc.start) + SUMW'(n_pos);
    assign note_raddr   = note_sum[AW-1:0];

    assign sid_ext      = SIDW'(in_sid);
    assign sid_idx      = sid_ext[SB-1:0];
    assign sid_in_range = (32'(in_sid) < NUM_SONGS);
    assign song_we      = in_xfer && (in_cmd == CMD_LOAD_SONG) && sid_in_range;

    tss_ram #(
        .WIDTH (SW),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (note_we),
        .i_waddr (note_waddr),
        .i_wdata (in_nper[SW-1:0]),
        .i_re    (in_xfer),
        .i_raddr (note_raddr),
        .o_rdata (note_rdata)
    );

    tss_ram #(
        .WIDTH (DESC_W),
        .DEPTH (NUM_SONGS)
    ) u_song_ram (
        .i_clk   (i_clk),
        .i_we    (song_we),
        .i_waddr (sid_idx),
        .i_wdata (in_desc),
        .i_re    (in_xfer),
        .i_raddr (sid_idx),
        .o_rdata (song_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: apply the command to the sequencer state
    // ------------------------------------------------------------------
    logic [SIDW-1:0] sid1_ext;
    logic            sid1_in_range;
    logic            sid1_valid_play;

    assign sid1_ext        = SIDW'(r_sid1);
    assign sid1_in_range   = (32'(r_sid1) < NUM_SONGS);
    assign sid1_valid_play = (r_sid1 != '0) && sid1_in_range;

    always_comb begin
        logic [TICKS_W-1:0] tc_inc;
        logic [LEN_W-1:0]   pos_inc;

        tc_inc    = r_tc + 1'b1;
        pos_inc   = r_pos + 1'b1;

        n_cur     = r_cur;
        n_active  = r_active;
        n_stop    = r_stop;
        n_pos     = r_pos;
        n_tc      = r_tc;
        n_period  = r_period;
        n_playing = r_playing;
        n_desc    = r_desc;
        n_notify  = 1'b0;

        if (s1_go) begin
            case (r_cmd1)
                CMD_TICK: begin
                    if (r_active && r_stop) begin
                        // pending stop wins over the note step
                        n_period  = '0;
                        n_playing = 1'b0;
                        n_active  = 1'b0;
                        n_notify  = 1'b1;
                        n_stop    = 1'b0;
                    end else if (r_active) begin
                        if (r_pos == '0 && r_tc == '0) begin
                            n_playing = 1'b1;
                            n_notify  = 1'b1;
                        end
                        if (r_tc == '0) begin
                            n_period = NPER_W'(note_rdata);
                        end
                        if (tc_inc == r_desc.ticks) begin
                            n_tc  = '0;
                            n_pos = pos_inc;
                            if (r_desc.rest) begin
                                n_period = '0;
                            end
                            if (pos_inc == r_desc.length) begin
                                // last note done: end the song
                                n_period  = '0;
                                n_playing = 1'b0;
                                n_active  = 1'b0;
                                n_notify  = 1'b1;
                            end
                        end else begin
                            n_tc = tc_inc;
                        end
                    end
                end
                CMD_PLAY: begin
                    if (sid1_valid_play) begin
                        n_cur    = sid1_ext[SB-1:0];
                        n_active = 1'b1;
                        n_pos    = '0;
                        n_tc     = '0;
                        n_stop   = 1'b0;
                        n_desc   = t_desc'(song_rdata);
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                CMD_STOP: begin
                    n_stop = 1'b1;
                end
                CMD_LOAD_SONG: begin
                    // keep the working copy in step with the table
                    if (sid1_in_range && (sid1_ext[SB-1:0] == r_cur)) begin
                        n_desc = r_pay1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [NPER_W-1:0] r_out_period;
    logic              r_out_playing;
    logic              r_out_notify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_ov      <= 1'b0;
            r_cur     <= '0;
            r_active  <= 1'b0;
            r_stop    <= 1'b0;
            r_pos     <= '0;
            r_tc      <= '0;
            r_period  <= '0;
            r_playing <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (s1_go) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            r_cur     <= n_cur;
            r_active  <= n_active;
            r_stop    <= n_stop;
            r_pos     <= n_pos;
            r_tc      <= n_tc;
            r_period  <= n_period;
            r_playing <= n_playing;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        if (in_xfer) begin
            r_cmd1 <= in_cmd;
            r_sid1 <= in_sid;
            r_pay1 <= in_desc;
        end
        if (s1_go) begin
            r_out_period  <= n_period;
            r_out_playing <= n_playing;
            r_out_notify  <= n_notify;
        end
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {
        7'd0,
        r_out_notify,
        r_out_playing,
        r_out_period[NPER_W-1:1],
        r_out_period
    };

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_play_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_active)
        else $error("playing status set without an active song");

    a_tone_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period != '0) |-> r_active)
        else $error("tone period nonzero without an active song");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_ov))
        else $error("input stalled while the pipeline has room");

    a_notify_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_cmd1 != CMD_TICK)) |=> !r_out_notify)
        else $error("status notification from a command other than tick");

    a_stop_ends_song: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_cmd1 == CMD_TICK) && r_active && r_stop) |=> (!r_active && !r_stop))
        else $error("pending stop not applied on tick");

endmodule

`default_nettype wire

@@ rtl/core/tss_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ tb/tss_result_checker.sv @@
// Result checker for the tone song sequencer: predicts each result from input transfers and compares.
module tss_result_checker #(
    parameter int NOTE_DEPTH = tss_pkg::DEF_NOTE_DEPTH,
    parameter int NUM_SONGS  = tss_pkg::DEF_NUM_SONGS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [tss_pkg::S_DATA_W-1:0] i_in_data,
    input  logic [tss_pkg::S_USER_W-1:0] i_in_user,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [tss_pkg::M_DATA_W-1:0] i_out_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    // Input payload layout, low field first
    localparam int ADDR_LSB  = SID_W;
    localparam int PER_LSB   = ADDR_LSB + NADDR_W;
    localparam int START_LSB = PER_LSB + NPER_W;
    localparam int LEN_LSB   = START_LSB + START_W;
    localparam int TICKS_LSB = LEN_LSB + LEN_W;
    localparam int REST_BIT  = TICKS_LSB + TICKS_W;

    // Same order as the low bits of the output payload
    typedef struct packed {
        logic              notify;
        logic              playing;
        logic [CMP_W-1:0]  compare;
        logic [NPER_W-1:0] period;
    } t_tone_state;

    logic [NPER_W-1:0]  note_mem [NOTE_DEPTH];
    t_desc              song_mem [NUM_SONGS];
    logic [SID_W-1:0]   cur_song;
    logic               song_on;
    logic               stop_req;
    logic               playing_now;
    logic [LEN_W-1:0]   note_pos;
    logic [TICKS_W-1:0] tick_cnt;
    logic [NPER_W-1:0]  period_now;

    t_tone_state tone_queue [$];
    int          mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%t tss_result_checker: %s: expected %0h, got %0h",
                 $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Silence the tone; tell whether a song was actually ended
    function automatic logic close_song();
        logic was_on;
        was_on     = song_on;
        period_now = '0;
        if (song_on) begin
            playing_now = 1'b0;
            song_on     = 1'b0;
        end
        return was_on;
    endfunction

    function automatic t_tone_state advance_sequencer(input logic [CMD_W-1:0] cmd,
                                                      input logic [S_DATA_W-1:0] data);
        logic [SID_W-1:0] sid;
        t_desc            desc;
        logic             notify;
        t_tone_state      res;
        sid    = data[SID_W-1:0];
        notify = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (song_on) begin
                    if (stop_req) begin
                        notify   = close_song();
                        stop_req = 1'b0;
                    end else begin
                        desc = song_mem[cur_song];
                        if (note_pos == '0 && tick_cnt == '0) begin
                            playing_now = 1'b1;
                            notify      = 1'b1;
                        end
                        if (tick_cnt == '0)
                            period_now =
                                note_mem[(int'(desc.start) + int'(note_pos)) % NOTE_DEPTH];
                        tick_cnt = tick_cnt + 1'b1;
                        if (tick_cnt == desc.ticks) begin
                            tick_cnt = '0;
                            if (desc.rest)
                                period_now = '0;
                            note_pos = note_pos + 1'b1;
                            if (note_pos == desc.length)
                                notify = close_song() | notify;
                        end
                    end
                end
            end
            CMD_PLAY: begin
                if (sid == '0 || int'(sid) >= NUM_SONGS) begin
                    stop_req = 1'b1;
                end else begin
                    cur_song = sid;
                    song_on  = 1'b1;
                    note_pos = '0;
                    tick_cnt = '0;
                    stop_req = 1'b0;
                end
            end
            CMD_STOP: begin
                stop_req = 1'b1;
            end
            CMD_LOAD_NOTE: begin
                note_mem[int'(data[ADDR_LSB +: NADDR_W]) % NOTE_DEPTH] = data[PER_LSB +: NPER_W];
            end
            CMD_LOAD_SONG: begin
                if (int'(sid) < NUM_SONGS) begin
                    desc.start  = data[START_LSB +: START_W];
                    desc.length = data[LEN_LSB +: LEN_W];
                    desc.ticks  = data[TICKS_LSB +: TICKS_W];
                    desc.rest   = data[REST_BIT];
                    song_mem[sid] = desc;
                end
            end
            default: begin
            end
        endcase
        res.period  = period_now;
        res.compare = period_now[NPER_W-1:1];
        res.playing = playing_now;
        res.notify  = notify;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tone_state got;
        t_tone_state want;
        if (!i_rst_n) begin
            cur_song    <= '0;
            song_on     <= 1'b0;
            stop_req    <= 1'b0;
            playing_now <= 1'b0;
            note_pos    <= '0;
            tick_cnt    <= '0;
            period_now  <= '0;
            tone_queue.delete();
        end else begin
            // Results pass stage 1 and the result register, so none belongs to this edge's input
            if (i_in_valid && i_in_ready)
                tone_queue.push_back(advance_sequencer(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[$bits(t_tone_state)-1:0];
                if (tone_queue.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, 32'(got));
                end else begin
                    want = tone_queue.pop_front();
                    if (got.period !== want.period)
                        report_mismatch("tone_period", 32'(want.period), 32'(got.period));
                    if (got.compare !== want.compare)
                        report_mismatch("tone_compare", 32'(want.compare), 32'(got.compare));
                    if (got.playing !== want.playing)
                        report_mismatch("playing", 32'(want.playing), 32'(got.playing));
                    if (got.notify !== want.notify)
                        report_mismatch("status_notify", 32'(want.notify), 32'(got.notify));
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= tone_queue.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the tone song sequencer testbench: clock, reset, stimulus, output stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    // Input payload layout, low field first
    localparam int ADDR_LSB  = SID_W;
    localparam int PER_LSB   = ADDR_LSB + NADDR_W;
    localparam int START_LSB = PER_LSB + NPER_W;
    localparam int LEN_LSB   = START_LSB + START_W;
    localparam int TICKS_LSB = LEN_LSB + LEN_W;
    localparam int REST_BIT  = TICKS_LSB + TICKS_W;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_LOAD_SONG + 1'b1;
    localparam logic [CMD_W-1:0] CMD_LAST         = '1;

    localparam int ITEM_TARGET    = 950;    // includes the 256-tick note
    localparam int STALL_CYCLES   = 64;     // long output hold-off
    localparam int DRAIN_CYCLES   = 12;     // wait past the last result for strays
    localparam int LONG_TICK_SONG = 2;      // episode that plays a 256-tick note
    localparam int ZERO_LEN_SONG  = 4;      // episode that plays a song of length zero
    localparam int ZERO_LEN_TICKS = 24;     // ticks spent in the length-zero song

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_results;
    int items_sent = 0;
    bit song_ready [DEF_NUM_SONGS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tone_song_sequencer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tss_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // In the third hundred of every four hundred items both sides run without gaps
    function automatic bit calm_now();
        return (items_sent / 100) % 4 == 2;
    endfunction

    // Random payload for every field; pad bits stay zero, length stays in 0..256
    function automatic logic [S_DATA_W-1:0] random_fields();
        logic [63:0]         raw;
        logic [S_DATA_W-1:0] d;
        raw = {$urandom(), $urandom()};
        d   = raw[S_DATA_W-1:0];
        d[LEN_LSB +: LEN_W] = LEN_W'($urandom_range(0, 256));
        d[S_DATA_W-1:REST_BIT+1] = '0;
        return d;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [S_DATA_W-1:0] data);
        int gap;
        int roll;
        gap = 0;
        if (!calm_now()) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick();
        push_item(CMD_TICK, random_fields());
    endtask

    task automatic send_play(input logic [SID_W-1:0] sid);
        logic [S_DATA_W-1:0] d;
        d = random_fields();
        d[SID_W-1:0] = sid;
        push_item(CMD_PLAY, d);
    endtask

    task automatic send_note(input logic [NADDR_W-1:0] addr, input logic [NPER_W-1:0] per);
        logic [S_DATA_W-1:0] d;
        d = random_fields();
        d[ADDR_LSB +: NADDR_W] = addr;
        d[PER_LSB +: NPER_W]   = per;
        push_item(CMD_LOAD_NOTE, d);
    endtask

    task automatic send_song(input logic [SID_W-1:0] sid, input logic [START_W-1:0] start,
                             input logic [LEN_W-1:0] len, input logic [TICKS_W-1:0] ticks,
                             input logic rest);
        logic [S_DATA_W-1:0] d;
        d = random_fields();
        d[SID_W-1:0]             = sid;
        d[START_LSB +: START_W]  = start;
        d[LEN_LSB +: LEN_W]      = len;
        d[TICKS_LSB +: TICKS_W]  = ticks;
        d[REST_BIT]              = rest;
        push_item(CMD_LOAD_SONG, d);
        song_ready[sid] = 1'b1;
    endtask

    // Stimulus
    initial begin : stimulus
        int          episode;
        int          sid;
        int          pick;
        int          roll;
        int          span;
        logic [8:0]  len;
        logic [7:0]  ticks;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle behavior, pending stop, play of song zero, which only requests a stop
        send_tick();
        push_item(CMD_STOP, random_fields());
        send_tick();
        send_play('0);

        // Notes at both ends of the store, extreme periods
        send_note(8'd255, 16'hFFFF);
        send_note(8'd0, 16'h0000);
        send_note(8'd1, 16'h8001);

        // Song 7 wraps from the top address back to zero, rests after each note
        send_song(3'd7, 8'd255, 9'd3, 8'd1, 1'b1);
        send_song(3'd1, 8'd0, 9'd2, 8'd2, 1'b0);
        send_song(3'd0, 8'd0, 9'd1, 8'd1, 1'b0);
        push_item(CMD_FIRST_UNUSED, random_fields());
        push_item(CMD_LAST, random_fields());

        // Valid play clears the stop left pending while idle
        send_play(3'd7);
        repeat (4) send_tick();

        // Restart while playing, then a stop that lands on the next tick
        send_play(3'd1);
        send_tick();
        send_tick();
        send_play(3'd1);
        send_tick();
        push_item(CMD_STOP, random_fields());
        send_tick();
        send_tick();

        // Fill the whole store so no note read ever hits an unwritten entry
        for (int a = 0; a < DEF_NOTE_DEPTH; a++) begin
            roll = $urandom_range(0, 15);
            send_note(NADDR_W'(a), (roll == 0) ? 16'h0000 :
                                   (roll == 1) ? 16'hFFFF : 16'($urandom_range(1, 65534)));
        end

        // Random songs: load, play, tick through, with some noise in between
        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            sid  = $urandom_range(1, DEF_NUM_SONGS - 1);
            roll = $urandom_range(0, 99);
            if (episode == LONG_TICK_SONG) begin
                len   = 9'd1;
                ticks = 8'd0;       // note lasts 256 ticks
            end else if (episode == ZERO_LEN_SONG) begin
                len   = 9'd0;       // position wraps at 9 bits
                ticks = TICKS_W'($urandom_range(1, 2));
            end else if (roll < 10) begin
                len   = LEN_W'($urandom_range(8, 24));
                ticks = TICKS_W'($urandom_range(1, 2));
            end else begin
                len   = LEN_W'($urandom_range(1, 6));
                ticks = TICKS_W'($urandom_range(1, 3));
            end
            send_song(SID_W'(sid), START_W'($urandom_range(0, 255)), len, ticks,
                      1'($urandom_range(0, 1)));
            send_play(SID_W'(sid));
            if (episode == ZERO_LEN_SONG)
                span = ZERO_LEN_TICKS + $urandom_range(0, 3);
            else
                span = int'(len) * ((ticks == 0) ? 256 : int'(ticks)) + $urandom_range(0, 3);
            repeat (span) begin
                // keep the 256-tick note free of stops and restarts
                if (episode != LONG_TICK_SONG && $urandom_range(0, 99) < 8) begin
                    case ($urandom_range(0, 5))
                        0: send_note(NADDR_W'($urandom_range(0, 255)),
                                     NPER_W'($urandom_range(0, 65535)));
                        1: send_song(SID_W'($urandom_range(0, DEF_NUM_SONGS - 1)),
                                     START_W'($urandom_range(0, 255)),
                                     LEN_W'($urandom_range(0, 256)),
                                     TICKS_W'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)));
                        2: push_item(CMD_STOP, random_fields());
                        3: begin
                            pick = $urandom_range(0, DEF_NUM_SONGS - 1);
                            send_play(SID_W'(song_ready[pick] ? pick : 0));
                        end
                        4: push_item(CMD_W'($urandom_range(int'(CMD_FIRST_UNUSED),
                                                           int'(CMD_LAST))),
                                     random_fields());
                        default: send_play(SID_W'(sid));
                    endcase
                end
                send_tick();
            end
            episode++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("tone_song_sequencer_unit regression: pass");
        else
            $display("tone_song_sequencer_unit regression: fail");
        $finish;
    end

    // Output side: random stalls, plus long hold-offs that back the block up to its input
    initial begin : drain_side
        int run;
        int hold;
        int roll;
        int next_stall;
        next_stall = 300;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (items_sent >= next_stall) begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                next_stall += 500;
            end
            m_axis_tready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge i_clk);
            if (!calm_now()) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    hold = $urandom_range(1, 2);
                else if (roll < 90)
                    hold = $urandom_range(3, 6);
                else
                    hold = $urandom_range(10, 30);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Hard stop for a hung run
    initial begin : run_limit
        #2_000_000;
        $display("tone_song_sequencer_unit regression: fail");
        $finish;
    end

endmodule
